[rtl/core/ptb_pkg.sv]
`default_nettype none

package ptb_pkg;

  // histogram geometry
  localparam int LEVELS     = 256;
  localparam int LVL_W      = $clog2(LEVELS);
  localparam int MAX_PIXELS = 1048576;
  localparam int CNT_W      = $clog2(MAX_PIXELS + 1);

  // percentile setting and compare scale
  localparam int PCT_W      = 14;
  localparam int PCT_RESET  = 5000;
  localparam int SCALE      = 10000;
  localparam int PROD_W     = CNT_W + PCT_W;

  // stream field widths
  localparam int PIX_W      = 8;
  localparam int VAL_W      = 8;

  // command and result kinds
  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;
  localparam logic KIND_REPORT  = 1'b0;
  localparam logic KIND_PIXEL   = 1'b1;

  // histogram port controls
  typedef struct packed {
    logic             rd_en;
    logic [LVL_W-1:0] rd_addr;
    logic             wr_en;
    logic [LVL_W-1:0] wr_addr;
    logic [CNT_W-1:0] wr_data;
    logic             clr;
  } hist_ctl_t;

endpackage

`default_nettype wire

[rtl/core/percentile_threshold_binarizer.sv]
`default_nettype none
// classify item: result registered at accept, 1 item per cycle unless the output stalls
// load item without last: histogram read, then write of the incremented bin
// load item with last: read and write as above, then the target product and a scan
//   of one bin at a time through the shared multiplier, then the threshold report
// rst_n is synchronous, active low: histogram and pixel count cleared, threshold 255,
//   percent 5000; histogram entries are marked empty by valid flops, no clearing pass

module percentile_threshold_binarizer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input stream
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [ptb_pkg::PIX_W-1:0]   in_tdata,   // [7:0] pixel
  input  wire logic                        in_tuser,   // [0] command
  input  wire logic                        in_tlast,   // last
  // result stream
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [ptb_pkg::VAL_W-1:0]        out_tdata,  // [7:0] value
  output logic                             out_tuser,  // [0] kind
  output logic                             out_tlast,  // end_of_pass
  // percentile setting
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [ptb_pkg::PCT_W-1:0]   cfg_data    // percent_hundredths
);
  import ptb_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,  // waiting for an item
    S_LD_WR = 8'b0000_0010,  // bin count back from ram, write +1
    S_TGT   = 8'b0000_0100,  // percent * pixel count into multiplier
    S_TGL   = 8'b0000_1000,  // latch target, read bin 0
    S_ACC   = 8'b0001_0000,  // add bin to cumulative count
    S_MUL   = 8'b0010_0000,  // cumulative * 10000 into multiplier
    S_CMP   = 8'b0100_0000,  // compare against target, step level
    S_DONE  = 8'b1000_0000   // report threshold, clear histogram
  } state_t;

  state_t            state_r, state_nxt;
  logic [PCT_W-1:0]  percent_r;
  logic [CNT_W-1:0]  pixel_count_r, pixel_count_nxt;
  logic [VAL_W-1:0]  threshold_r, threshold_nxt;
  logic [LVL_W-1:0]  bin_r, bin_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic [CNT_W-1:0]  cum_r, cum_nxt;
  logic [PROD_W-1:0] target_r, target_nxt;
  logic              last_r, last_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]  out_value_r, out_value_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic              out_last_r, out_last_nxt;

  hist_ctl_t         hctl;
  logic [CNT_W-1:0]  rd_data;
  logic [CNT_W-1:0]  mul_a;
  logic [PCT_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_p;

  logic              out_free;
  logic              in_fire;
  logic [LVL_W-1:0]  in_bin;
  logic              room;

  // histogram ram with per-bin valid flops
  ptb_hist u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (hctl),
    .rd_data (rd_data)
  );

  // one multiplier shared by the target product and every scan step
  ptb_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  // output register drains in the same cycle it is refilled
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // levels at or above LEVELS land in the top bin
  assign in_bin = ({1'b0, in_tdata} >= (PIX_W + 1)'(LEVELS)) ? LVL_W'(LEVELS - 1)
                                                               : LVL_W'(in_tdata);
  assign room   = pixel_count_r < CNT_W'(MAX_PIXELS);

  always_comb begin
    mul_a = cum_r;
    mul_b = PCT_W'(SCALE);
    if (state_r == S_TGT) begin
      mul_a = pixel_count_r;
      mul_b = percent_r;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    pixel_count_nxt = pixel_count_r;
    threshold_nxt   = threshold_r;
    bin_nxt         = bin_r;
    lvl_nxt         = lvl_r;
    cum_nxt         = cum_r;
    target_nxt      = target_r;
    last_nxt        = last_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_value_nxt   = out_value_r;
    out_kind_nxt    = out_kind_r;
    out_last_nxt    = out_last_r;
    hctl            = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_tuser == CMD_CLASSIFY) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_PIXEL;
            out_value_nxt = (in_tdata < threshold_r) ? '0 : VAL_W'(LEVELS - 1);
            out_last_nxt  = in_tlast;
          end else begin
            // fetch the bin count for read-modify-write
            hctl.rd_en   = 1'b1;
            hctl.rd_addr = in_bin;
            bin_nxt      = in_bin;
            last_nxt     = in_tlast;
            state_nxt    = S_LD_WR;
          end
        end
      end
      S_LD_WR: begin
        if (room) begin
          hctl.wr_en      = 1'b1;
          hctl.wr_addr    = bin_r;
          hctl.wr_data    = rd_data + CNT_W'(1);
          pixel_count_nxt = pixel_count_r + CNT_W'(1);
        end
        state_nxt = last_r ? S_TGT : S_IDLE;
      end
      S_TGT: begin
        state_nxt = S_TGL;
      end
      S_TGL: begin
        target_nxt   = mul_p;
        hctl.rd_en   = 1'b1;
        hctl.rd_addr = '0;
        lvl_nxt      = '0;
        cum_nxt      = '0;
        state_nxt    = S_ACC;
      end
      S_ACC: begin
        cum_nxt   = cum_r + rd_data;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (mul_p > target_r) begin
          threshold_nxt = VAL_W'(lvl_r);
          state_nxt     = S_DONE;
        end else if (lvl_r == LVL_W'(LEVELS - 1)) begin
          // no level exceeds the target
          threshold_nxt = '1;
          state_nxt     = S_DONE;
        end else begin
          lvl_nxt      = lvl_r + LVL_W'(1);
          hctl.rd_en   = 1'b1;
          hctl.rd_addr = lvl_r + LVL_W'(1);
          state_nxt    = S_ACC;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = KIND_REPORT;
          out_value_nxt   = threshold_r;
          out_last_nxt    = 1'b1;
          hctl.clr        = 1'b1;
          pixel_count_nxt = '0;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      percent_r     <= PCT_W'(PCT_RESET);
      pixel_count_r <= '0;
      threshold_r   <= '1;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      pixel_count_r <= pixel_count_nxt;
      threshold_r   <= threshold_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        percent_r <= cfg_data;
      end
    end
  end

  // scan and output payload, no reset needed
  always_ff @(posedge clk) begin
    bin_r       <= bin_nxt;
    lvl_r       <= lvl_nxt;
    cum_r       <= cum_nxt;
    target_r    <= target_nxt;
    last_r      <= last_nxt;
    out_value_r <= out_value_nxt;
    out_kind_r  <= out_kind_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // pixel count never passes the cap
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    pixel_count_r <= CNT_W'(MAX_PIXELS))
    else $error("pixel count above cap");

  // a threshold report always closes a pass
  a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_REPORT) |-> out_tlast)
    else $error("report without end of pass");

  // report clears the pixel count for the next image
  a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (pixel_count_r == '0 && state_r == S_IDLE))
    else $error("pass state not cleared after report");

  // cumulative count stays within the loaded pixels during the scan
  a_cum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL || state_r == S_CMP) |-> cum_r <= pixel_count_r)
    else $error("cumulative count exceeds pixel count");

endmodule

`default_nettype wire

[rtl/core/ptb_hist.sv]
`default_nettype none

module ptb_hist (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ptb_pkg::hist_ctl_t ctl,
  output logic [ptb_pkg::CNT_W-1:0] rd_data
);
  import ptb_pkg::*;

  logic [CNT_W-1:0]  mem [LEVELS];
  logic [LEVELS-1:0] vld_r;
  logic [CNT_W-1:0]  rd_mem_r;
  logic              rd_vld_r;

  // entries not written since the last clear read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.clr) begin
      vld_r <= '0;
    end else if (ctl.wr_en) begin
      vld_r[ctl.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_mem_r <= mem[ctl.rd_addr];
      rd_vld_r <= vld_r[ctl.rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_mem_r : '0;

endmodule

`default_nettype wire

[rtl/core/ptb_mul.sv]
`default_nettype none

module ptb_mul (
  input  wire logic                       clk,
  input  wire logic [ptb_pkg::CNT_W-1:0]  a,
  input  wire logic [ptb_pkg::PCT_W-1:0]  b,
  output logic      [ptb_pkg::PROD_W-1:0] p_r
);
  import ptb_pkg::*;

  always_ff @(posedge clk) begin
    p_r <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

`default_nettype wire
